// ===== sv/ivs_pkg.sv =====
// ivs_pkg: request codes and result status codes for indexed_vector_store.
// No dependencies; imported by the top level and its port checker.
`default_nettype none

package ivs_pkg;

   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_GET   = 3'd2,
      OP_SET   = 3'd3,
      OP_SLICE = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_RANGE       = 2'd1,
      ST_FULL        = 2'd2,
      ST_EMPTY_SLICE = 2'd3
   } status_type;

endpackage

`default_nettype wire

// ===== sv/ivs_store.sv =====
// ivs_store: element memory, one write port and one read port with registered read data.
// No package dependency; instantiated by indexed_vector_store.
`default_nettype none

module ivs_store #(
   parameter int DEPTH      = 64,
   parameter int ELEM_WIDTH = 32,
   localparam int AddrW     = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AddrW-1:0]      wr_addr,
   input  wire logic [ELEM_WIDTH-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [AddrW-1:0]      rd_addr,
   output logic      [ELEM_WIDTH-1:0] rd_data
);

   logic [ELEM_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/indexed_vector_store.sv =====
// indexed_vector_store: push/pop/get/set/slice over a bounded element store.
// Timing: the accepting edge registers the request and enters the execute state. Push, pop,
//   get, plain set and all error cases give one result, registered from that state.
//   Slice: one memory read per cycle, one result per read. Set with extension: one memory
//   write per cycle, from the old length up to the index. Results cannot be stalled.
//   Synchronous reset empties the store (length 0) and sets set_extends to 1; memory
//   contents are not cleared.
// Depends on ivs_pkg and ivs_store.
`default_nettype none

module indexed_vector_store
   import ivs_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_type,
   input  wire logic signed [15:0] req_index,
   input  wire logic [31:0]        req_value,
   input  wire logic signed [15:0] req_slice_start,
   input  wire logic signed [15:0] req_slice_stop,
   input  wire logic signed [7:0]  req_slice_step,
   input  wire logic               req_start_omitted,
   input  wire logic               req_stop_omitted,
   input  wire logic               req_step_omitted,
   output logic                    rsp_strobe,
   output logic [31:0]             rsp_element_value,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last_flag,
   output logic [6:0]              rsp_current_length,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int AW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);
   localparam int IW = 18;
   localparam logic [2:0] ADDR_SET_EXTENDS = 3'd0;
   localparam logic signed [IW-1:0] DEPTH_S = IW'(DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SLICE, S_FILL} state_type;

   state_type             state_ff, state_in;
   logic [LW-1:0]         len_ff, len_in;
   logic                  set_ext_ff;
   logic                  strobe_ff, strobe_in;
   status_type            status_ff, status_in;
   logic                  last_ff, last_in;
   logic [6:0]            rlen_ff, rlen_in;
   logic                  from_mem_ff, from_mem_in;
   logic signed [IW-1:0]  i_ff, i_in;
   logic signed [IW-1:0]  stop_ff, stop_in;
   logic signed [7:0]     step_ff, step_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [AW-1:0]         tgt_ff, tgt_in;

   logic [2:0]            op_ff;
   logic signed [15:0]    idx_ff;
   logic [ELEM_WIDTH-1:0] val_ff;
   logic signed [15:0]    sstart_ff, sstop_ff;
   logic signed [7:0]     sstep_ff;
   logic                  start_om_ff, stop_om_ff, step_om_ff;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [ELEM_WIDTH-1:0] wr_data, rd_data;

   logic signed [IW-1:0]  len_s, idx_adj, start_c, stop_c, i_nx;
   logic signed [7:0]     step_eff;
   logic                  step_neg, slice_more, next_more;
   logic [LW-1:0]         len_dec, len_inc;

   function automatic logic signed [IW-1:0] clamp_index(
      input logic signed [IW-1:0] v,
      input logic signed [IW-1:0] size,
      input logic                 neg
   );
      logic signed [IW-1:0] a;
      a = (v < 0) ? v + size : v;
      if (!neg) begin
         if (a < 0)         a = '0;
         else if (a > size) a = size;
      end else begin
         if (a < 0)          a = -IW'(1);
         else if (a >= size) a = size - IW'(1);
      end
      return a;
   endfunction

   ivs_store #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy    = (state_ff != S_IDLE);
   assign pready  = 1'b1;
   assign prdata  = (paddr == ADDR_SET_EXTENDS) ? {31'b0, set_ext_ff} : 32'b0;

   assign rsp_strobe         = strobe_ff;
   assign rsp_element_value  = from_mem_ff ? 32'(rd_data) : 32'b0;
   assign rsp_status         = status_ff;
   assign rsp_last_flag      = last_ff;
   assign rsp_current_length = rlen_ff;

   assign len_s    = signed'(IW'(len_ff));
   assign len_dec  = len_ff - LW'(1);
   assign len_inc  = len_ff + LW'(1);
   assign idx_adj  = (idx_ff < 0) ? IW'(idx_ff) + len_s : IW'(idx_ff);
   assign step_eff = step_om_ff ? 8'sd1 : sstep_ff;
   assign step_neg = step_eff[7];
   assign start_c  = start_om_ff ? (step_neg ? len_s - IW'(1) : '0)
                                 : clamp_index(IW'(sstart_ff), len_s, step_neg);
   assign stop_c   = stop_om_ff ? (step_neg ? -IW'(1) : len_s)
                                : clamp_index(IW'(sstop_ff), len_s, step_neg);
   assign slice_more = step_neg ? (start_c > stop_c) : (start_c < stop_c);
   assign i_nx       = i_ff + IW'(step_ff);
   assign next_more  = step_ff[7] ? (i_nx > stop_ff) : (i_nx < stop_ff);

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      last_in     = last_ff;
      rlen_in     = rlen_ff;
      from_mem_in = 1'b0;
      i_in        = i_ff;
      stop_in     = stop_ff;
      step_in     = step_ff;
      ptr_in      = ptr_ff;
      tgt_in      = tgt_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in  = S_IDLE;
            strobe_in = 1'b1;
            last_in   = 1'b1;
            status_in = ST_OK;
            rlen_in   = 7'(len_ff);
            case (op_ff)
               OP_PUSH: begin
                  if (len_ff >= LW'(DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = len_ff[AW-1:0];
                     wr_data = val_ff;
                     len_in  = len_inc;
                     rlen_in = 7'(len_inc);
                  end
               end
               OP_POP: begin
                  if (len_ff == '0) begin
                     status_in = ST_RANGE;
                  end else begin
                     rd_en       = 1'b1;
                     rd_addr     = len_dec[AW-1:0];
                     from_mem_in = 1'b1;
                     len_in      = len_dec;
                     rlen_in     = 7'(len_dec);
                  end
               end
               OP_GET: begin
                  if (idx_adj < 0 || idx_adj >= len_s) begin
                     status_in = ST_RANGE;
                  end else begin
                     rd_en       = 1'b1;
                     rd_addr     = idx_adj[AW-1:0];
                     from_mem_in = 1'b1;
                  end
               end
               OP_SET: begin
                  if (idx_adj < 0) begin
                     status_in = ST_RANGE;
                  end else if (idx_adj < len_s) begin
                     wr_en   = 1'b1;
                     wr_addr = idx_adj[AW-1:0];
                     wr_data = val_ff;
                  end else if (!set_ext_ff) begin
                     status_in = ST_RANGE;
                  end else if (idx_adj >= DEPTH_S) begin
                     status_in = ST_FULL;
                  end else begin
                     strobe_in = 1'b0;
                     state_in  = S_FILL;
                     ptr_in    = len_ff[AW-1:0];
                     tgt_in    = idx_adj[AW-1:0];
                  end
               end
               OP_SLICE: begin
                  if (step_eff == 8'sd0 || !slice_more) begin
                     status_in = ST_EMPTY_SLICE;
                  end else begin
                     strobe_in = 1'b0;
                     state_in  = S_SLICE;
                     i_in      = start_c;
                     stop_in   = stop_c;
                     step_in   = step_eff;
                  end
               end
               default: begin
                  status_in = ST_RANGE;
               end
            endcase
         end
         S_SLICE: begin
            rd_en       = 1'b1;
            rd_addr     = i_ff[AW-1:0];
            strobe_in   = 1'b1;
            from_mem_in = 1'b1;
            status_in   = ST_OK;
            rlen_in     = 7'(len_ff);
            last_in     = !next_more;
            i_in        = i_nx;
            if (!next_more) begin
               state_in = S_IDLE;
            end
         end
         S_FILL: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = (ptr_ff == tgt_ff) ? val_ff : '0;
            if (ptr_ff == tgt_ff) begin
               len_in    = LW'(tgt_ff) + LW'(1);
               strobe_in = 1'b1;
               status_in = ST_OK;
               last_in   = 1'b1;
               rlen_in   = 7'(LW'(tgt_ff) + LW'(1));
               state_in  = S_IDLE;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         len_ff     <= '0;
         strobe_ff  <= 1'b0;
         set_ext_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         strobe_ff <= strobe_in;
         if (psel && penable && pwrite && pready && paddr == ADDR_SET_EXTENDS) begin
            set_ext_ff <= pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      last_ff     <= last_in;
      rlen_ff     <= rlen_in;
      from_mem_ff <= from_mem_in;
      i_ff        <= i_in;
      stop_ff     <= stop_in;
      step_ff     <= step_in;
      ptr_ff      <= ptr_in;
      tgt_ff      <= tgt_in;
      if (state_ff == S_IDLE && start) begin
         op_ff       <= req_type;
         idx_ff      <= req_index;
         val_ff      <= ELEM_WIDTH'(req_value);
         sstart_ff   <= req_slice_start;
         sstop_ff    <= req_slice_stop;
         sstep_ff    <= req_slice_step;
         start_om_ff <= req_start_omitted;
         stop_om_ff  <= req_stop_omitted;
         step_om_ff  <= req_step_omitted;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ivs_checker.sv =====
// ivs_checker: port-level assertions for indexed_vector_store, bound to the top level.
// Depends on ivs_pkg for the status codes.
`default_nettype none

module ivs_checker
   import ivs_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_strobe,
   input wire logic [31:0] rsp_element_value,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_last_flag
);

   // a multi-result transaction delivers its results back to back
   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_flag |=> rsp_strobe)
      else $error("result burst broken before last_flag");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !rsp_strobe)
      else $error("result without a transaction in progress");

   a_empty_slice: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_EMPTY_SLICE |-> rsp_last_flag && rsp_element_value == 32'b0)
      else $error("empty slice result malformed");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ST_FULL || rsp_status == ST_RANGE)
      |-> rsp_last_flag && rsp_element_value == 32'b0)
      else $error("error result malformed");

endmodule

bind indexed_vector_store ivs_checker u_ivs_checker (.*);

`default_nettype wire
